// ===== hw/rtl/sha256_message_hasher_assert.svh =====
// Assertion macros shared by the SHA-256 hasher modules.
`ifndef SHA256_MESSAGE_HASHER_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SHA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sha256_pkg.sv =====
// Shared types and constants for the SHA-256 message hasher.
package sha256_pkg;

    localparam logic [7:0] PAD_MARKER    = 8'h80;
    localparam logic [5:0] LAST_BYTE_POS = 6'd63;
    localparam logic [5:0] LEN_POS       = 6'd56;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;

    localparam logic [31:0] HASH_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic       shift_en;
        logic [7:0] shift_byte;
        logic       start;
        logic       init_hash;
        logic [2:0] rd_index;
    } core_ctrl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } core_status_t;

endpackage

// ===== hw/rtl/sha256_byte_if.sv =====
// Handshake channel carrying one message byte beat.
interface sha256_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_end;

    modport source (output valid, output data_byte, output byte_valid, output message_end,
                    input ready);
    modport sink (input valid, input data_byte, input byte_valid, input message_end,
                  output ready);
endinterface

// ===== hw/rtl/sha256_digest_if.sv =====
// Handshake channel carrying one digest word beat.
interface sha256_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

// ===== hw/rtl/sha256_core.sv =====
// SHA-256 compression engine: byte shift-in window, one round per cycle, hash state.
`include "sha256_message_hasher_assert.svh"

module sha256_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sha256_pkg::core_ctrl_t    ctrl,
    output sha256_pkg::core_status_t  status,
    output logic [31:0]               rd_word
);

    typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} core_state_t;

    core_state_t       state_reg, state_next;
    logic [5:0]        rnd_reg, rnd_next;
    logic [31:0]       hash_reg [8];
    logic [31:0]       hash_next [8];
    logic [31:0]       vars_reg [8];
    logic [31:0]       vars_next [8];
    // Element 15 holds the oldest schedule word, element 0 the newest.
    logic [15:0][31:0] win_reg, win_next;
    logic [31:0]       w_t, t1, t2;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    always_comb
    begin
        if (rnd_reg[5:4] == 2'b00)
        begin
            w_t = win_reg[15];
        end
        else
        begin
            w_t = ssig1(win_reg[1]) + win_reg[6] + ssig0(win_reg[14]) + win_reg[15];
        end
        t1 = vars_reg[7] + bsig1(vars_reg[4])
             + ((vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]))
             + sha256_pkg::ROUND_K[rnd_reg] + w_t;
        t2 = bsig0(vars_reg[0])
             + ((vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
                ^ (vars_reg[1] & vars_reg[2]));
    end

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        win_next   = win_reg;
        for (int i = 0; i < 8; i++)
        begin
            hash_next[i] = hash_reg[i];
            vars_next[i] = vars_reg[i];
        end

        if (ctrl.shift_en)
        begin
            win_next = {win_reg[15][23:0], win_reg[14:0], ctrl.shift_byte};
        end
        if (ctrl.init_hash)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_next[i] = sha256_pkg::HASH_INIT[i];
            end
        end

        unique case (state_reg)
            C_IDLE:
            begin
                if (ctrl.start)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        vars_next[i] = hash_reg[i];
                    end
                    rnd_next   = '0;
                    state_next = C_ROUND;
                end
            end
            C_ROUND:
            begin
                win_next = {win_reg[14:0], w_t};
                for (int i = 1; i < 8; i++)
                begin
                    vars_next[i] = vars_reg[i - 1];
                end
                vars_next[4] = vars_reg[3] + t1;
                vars_next[0] = t1 + t2;
                rnd_next     = rnd_reg + 6'd1;
                if (rnd_reg == sha256_pkg::LAST_ROUND)
                begin
                    state_next = C_ADD;
                end
            end
            C_ADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_next[i] = hash_reg[i] + vars_reg[i];
                end
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            rnd_reg   <= '0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= sha256_pkg::HASH_INIT[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= hash_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        for (int i = 0; i < 8; i++)
        begin
            vars_reg[i] <= vars_next[i];
        end
    end

    assign status.idle = (state_reg == C_IDLE);
    assign status.done = (state_reg == C_ADD);
    assign rd_word     = hash_reg[ctrl.rd_index];

    `SHA_ASSERT_NOW(a_start_when_idle, ctrl.start, state_reg == C_IDLE, "start while busy")
    `SHA_ASSERT_NEXT(a_add_after_last, (state_reg == C_ROUND) && (rnd_reg == sha256_pkg::LAST_ROUND), state_reg == C_ADD, "no add after last round")
    `SHA_ASSERT_NEXT(a_idle_after_add, state_reg == C_ADD, (state_reg == C_IDLE) && (rnd_reg == 6'd0), "round count not back at zero")

endmodule

// ===== hw/rtl/sha256_message_hasher.sv =====
// A plain byte beat is taken in S_IDLE; each 64th byte starts 64 rounds and a hash
// add in the shared round unit, and message.ready stays low until they are done.
// Final beat: padding goes in 1 byte per cycle to the block end, which is compressed;
// both twice when 56 or more bytes are buffered; then 8 digest beats, 1 per cycle
// while digest.ready is high. Throughput is set by the one-round-per-cycle core.
// Reset (rst_n, async, active low) loads the initial hash and empties the block.
`include "sha256_message_hasher_assert.svh"

module sha256_message_hasher (
    input  logic                   clk,
    input  logic                   rst_n,
    sha256_byte_if.sink            message,
    sha256_digest_if.source        digest
);

    typedef enum logic [1:0] {S_IDLE, S_COMP, S_PAD, S_OUT} state_t;

    state_t      state_reg, state_next;
    logic [5:0]  count_reg, count_next;
    logic [60:0] total_reg, total_next;
    logic        end_pend_reg, end_pend_next;
    logic        pad_reg, pad_next;
    logic        marker_reg, marker_next;
    logic        lenphase_reg, lenphase_next;
    logic [2:0]  idx_reg, idx_next;

    sha256_pkg::core_ctrl_t   ctrl;
    sha256_pkg::core_status_t status;
    logic [31:0]              rd_word;

    logic [63:0] len_bits;
    logic [2:0]  len_sel;
    logic [7:0]  len_byte;
    logic [7:0]  pad_byte;

    sha256_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .status (status),
        .rd_word(rd_word)
    );

    // Length bytes go out most significant first at block positions 56..63.
    always_comb
    begin
        len_bits = {total_reg, 3'b000};
        len_sel  = ~count_reg[2:0];
        len_byte = len_bits[{len_sel, 3'b000} +: 8];
        if (!marker_reg)
        begin
            pad_byte = sha256_pkg::PAD_MARKER;
        end
        else if (lenphase_reg && (count_reg >= sha256_pkg::LEN_POS))
        begin
            pad_byte = len_byte;
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        end_pend_next = end_pend_reg;
        pad_next      = pad_reg;
        marker_next   = marker_reg;
        lenphase_next = lenphase_reg;
        idx_next      = idx_reg;

        ctrl            = '0;
        ctrl.rd_index   = idx_reg;
        ctrl.shift_byte = message.data_byte;

        unique case (state_reg)
            S_IDLE:
            begin
                if (message.valid)
                begin
                    if (message.byte_valid)
                    begin
                        ctrl.shift_en = 1'b1;
                        total_next    = total_reg + 61'd1;
                        count_next    = count_reg + 6'd1;
                    end
                    if (message.byte_valid && (count_reg == sha256_pkg::LAST_BYTE_POS))
                    begin
                        ctrl.start    = 1'b1;
                        end_pend_next = message.message_end;
                        state_next    = S_COMP;
                    end
                    else if (message.message_end)
                    begin
                        pad_next    = 1'b1;
                        marker_next = 1'b0;
                        state_next  = S_PAD;
                    end
                end
            end
            S_COMP:
            begin
                if (status.done)
                begin
                    if (!pad_reg)
                    begin
                        if (end_pend_reg)
                        begin
                            pad_next    = 1'b1;
                            marker_next = 1'b0;
                            state_next  = S_PAD;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else if (lenphase_reg)
                    begin
                        idx_next   = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        // marker spilled past the length field: pad one more block
                        lenphase_next = 1'b1;
                        state_next    = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                ctrl.shift_en   = 1'b1;
                ctrl.shift_byte = pad_byte;
                count_next      = count_reg + 6'd1;
                if (!marker_reg)
                begin
                    marker_next   = 1'b1;
                    lenphase_next = (count_reg < sha256_pkg::LEN_POS);
                end
                if (count_reg == sha256_pkg::LAST_BYTE_POS)
                begin
                    ctrl.start = 1'b1;
                    state_next = S_COMP;
                end
            end
            S_OUT:
            begin
                if (digest.ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == sha256_pkg::LAST_WORD_IDX)
                    begin
                        ctrl.init_hash = 1'b1;
                        total_next     = '0;
                        count_next     = '0;
                        pad_next       = 1'b0;
                        end_pend_next  = 1'b0;
                        lenphase_next  = 1'b0;
                        state_next     = S_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            total_reg    <= '0;
            end_pend_reg <= 1'b0;
            pad_reg      <= 1'b0;
            marker_reg   <= 1'b0;
            lenphase_reg <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            total_reg    <= total_next;
            end_pend_reg <= end_pend_next;
            pad_reg      <= pad_next;
            marker_reg   <= marker_next;
            lenphase_reg <= lenphase_next;
            idx_reg      <= idx_next;
        end
    end

    assign message.ready      = (state_reg == S_IDLE);
    assign digest.valid       = (state_reg == S_OUT);
    assign digest.digest_word = rd_word;
    assign digest.word_index  = idx_reg;
    assign digest.last_word   = (idx_reg == sha256_pkg::LAST_WORD_IDX);

    `SHA_ASSERT_NOW(a_no_overlap, message.ready, !digest.valid, "input taken while digest pending")
    `SHA_ASSERT_NEXT(a_idle_after_last,
        digest.valid && digest.ready && digest.last_word,
        message.ready && (count_reg == 6'd0) && (total_reg == 61'd0),
        "not reinitialised after digest")
    `SHA_ASSERT_NEXT(a_word_step,
        digest.valid && digest.ready && !digest.last_word,
        digest.valid && (digest.word_index == 3'($past(digest.word_index) + 3'd1)),
        "digest word skipped")
    `SHA_ASSERT_NOW(a_core_free, ctrl.start, status.idle, "compression started while busy")

endmodule

// ===== dv/sha256_hash_checker.sv =====
// Scoreboard: predicts SHA-256 digests from accepted byte beats and checks each digest beat.
module sha256_hash_checker (
    input  logic     clk,
    input  logic     rst_n,
    sha256_byte_if   message,
    sha256_digest_if digest,
    output int       fail_count,
    output int       pending,
    output int       words_checked,
    output int       messages_hashed
);

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    logic [31:0]  chain [8];
    logic [7:0]   block_bytes [64];
    logic [5:0]   fill;
    logic [60:0]  msg_len;
    digest_beat_t digest_due [$];

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Run the 64 rounds over block_bytes and fold the result into the chaining value.
    function automatic void fold_block();
        logic [31:0] sched [16];
        logic [31:0] v [8];
        logic [31:0] w, s0, s1, t1, t2;
        for (int i = 0; i < 8; i++)
            v[i] = chain[i];
        for (int t = 0; t < 64; t++)
        begin
            if (t < 16)
            begin
                w = {block_bytes[4 * t], block_bytes[4 * t + 1],
                     block_bytes[4 * t + 2], block_bytes[4 * t + 3]};
            end
            else
            begin
                // (t+1), (t+9), (t+14) mod 16 address words t-15, t-7 and t-2
                s0 = ror(sched[(t + 1) % 16], 7) ^ ror(sched[(t + 1) % 16], 18) ^
                     (sched[(t + 1) % 16] >> 3);
                s1 = ror(sched[(t + 14) % 16], 17) ^ ror(sched[(t + 14) % 16], 19) ^
                     (sched[(t + 14) % 16] >> 10);
                w = s1 + sched[(t + 9) % 16] + s0 + sched[t % 16];
            end
            sched[t % 16] = w;
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
                 ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[t] + w;
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
                 ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] = chain[i] + v[i];
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++)
            chain[i] = sha256_pkg::HASH_INIT[i];
        fill = '0;
        msg_len = '0;
    endfunction

    function automatic void absorb(input logic [7:0] d, input logic bv, input logic me);
        int           n;
        logic [63:0]  bit_len;
        digest_beat_t beat;
        if (bv)
        begin
            block_bytes[fill] = d;
            msg_len = msg_len + 1'b1;
            if (fill == sha256_pkg::LAST_BYTE_POS)
            begin
                fold_block();
                fill = '0;
            end
            else
                fill = fill + 1'b1;
        end
        if (!me)
            return;
        n = fill;
        block_bytes[n] = sha256_pkg::PAD_MARKER;
        for (int i = n + 1; i < 64; i++)
            block_bytes[i] = 8'h00;
        // No room left for the length field: spill it into a second block
        if (n >= sha256_pkg::LEN_POS)
        begin
            fold_block();
            for (int i = 0; i < 64; i++)
                block_bytes[i] = 8'h00;
        end
        bit_len = {msg_len, 3'b000};
        for (int i = 0; i < 8; i++)
            block_bytes[sha256_pkg::LEN_POS + i] = bit_len[63 - 8 * i -: 8];
        fold_block();
        for (int i = 0; i < 8; i++)
        begin
            beat.word = chain[i];
            beat.index = 3'(i);
            beat.last = (3'(i) == sha256_pkg::LAST_WORD_IDX);
            digest_due.push_back(beat);
        end
        messages_hashed++;
        restart_message();
    endfunction

    function automatic void check_word();
        digest_beat_t want;
        if (digest_due.size() == 0)
        begin
            fail_count++;
            $display("%0t: unexpected digest beat: expected none, got word=%h index=%0d last=%b",
                     $time, digest.digest_word, digest.word_index, digest.last_word);
            return;
        end
        want = digest_due.pop_front();
        words_checked++;
        if (digest.digest_word !== want.word)
        begin
            fail_count++;
            $display("%0t: digest_word mismatch at index %0d: expected %h, got %h",
                     $time, want.index, want.word, digest.digest_word);
        end
        if (digest.word_index !== want.index)
        begin
            fail_count++;
            $display("%0t: word_index mismatch: expected %0d, got %0d",
                     $time, want.index, digest.word_index);
        end
        if (digest.last_word !== want.last)
        begin
            fail_count++;
            $display("%0t: last_word mismatch at index %0d: expected %b, got %b",
                     $time, want.index, want.last, digest.last_word);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_message();
            digest_due.delete();
            fail_count = 0;
            words_checked = 0;
            messages_hashed = 0;
        end
        else
        begin
            // Retire the digest beat before queueing anything new
            if (digest.valid && digest.ready)
                check_word();
            if (message.valid && message.ready)
                absorb(message.data_byte, message.byte_valid, message.message_end);
        end
        pending = digest_due.size();
    end

endmodule

// ===== dv/tb_sha256_message_hasher.sv =====
// Testbench top: drives byte beats and digest back-pressure, reports the verdict.
module tb_sha256_message_hasher;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   words_checked;
    int   messages_hashed;
    int   bytes_sent;
    int   beats_sent;
    bit   steady;

    sha256_byte_if   message ();
    sha256_digest_if digest ();

    sha256_message_hasher uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .message (message),
        .digest  (digest)
    );

    sha256_hash_checker digest_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .message         (message),
        .digest          (digest),
        .fail_count      (fail_count),
        .pending         (pending),
        .words_checked   (words_checked),
        .messages_hashed (messages_hashed)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one beat and hold it until the hasher takes it.
    task automatic send_beat(input logic [7:0] d, input logic bv, input logic me);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            message.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        message.valid <= 1'b1;
        message.data_byte <= d;
        message.byte_valid <= bv;
        message.message_end <= me;
        do
            @(posedge clk);
        while (!message.ready);
        beats_sent++;
        if (bv)
            bytes_sent++;
    endtask

    // Random bytes with stray idle beats; end either on the last byte or on an empty beat.
    task automatic send_message(input int len);
        bit end_on_byte;
        end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte)
            send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    initial
    begin
        int       pad_lengths [2];
        bit [1:0] covered;
        int       len;
        int       k;
        pad_lengths = '{56, 64};
        covered = '0;
        bytes_sent = 0;
        beats_sent = 0;
        steady = 1'b0;
        rst_n = 1'b0;
        message.valid = 1'b0;
        message.data_byte = 8'h00;
        message.byte_valid = 1'b0;
        message.message_end = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: idle beat, empty messages, single extreme bytes, "abc", ignored data
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'hff, 1'b0, 1'b1);
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'hff, 1'b1, 1'b1);
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b1);
        send_beat(8'hff, 1'b1, 1'b0);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'ha5, 1'b0, 1'b1);

        // Random: short messages, plus a length-spill message and a full block
        while (covered != 2'b11)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                do
                    k = $urandom_range(0, 1);
                while (covered[k]);
                covered[k] = 1'b1;
                len = pad_lengths[k];
            end
            else
                len = $urandom_range(0, 6);
            steady = ($urandom_range(0, 3) == 0);
            send_message(len);
        end
        message.valid <= 1'b0;

        // Let the checker queue the final digest, then drain
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Sent %0d beats carrying %0d bytes; %0d messages hashed, %0d digest words checked",
                 beats_sent, bytes_sent, messages_hashed, words_checked);
        $display("Included empty and one-byte messages, idle beats, a full block and a length spill");
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Digest back-pressure: runs of ready, short stalls and the odd long one
    initial
    begin
        int r;
        digest.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                digest.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
            else if (r < 85)
            begin
                digest.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                digest.ready <= 1'b0;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
        end
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d digest words outstanding", pending);
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_byte_if.sv
hw/rtl/sha256_digest_if.sv
hw/rtl/sha256_core.sv
hw/rtl/sha256_message_hasher.sv
dv/sha256_hash_checker.sv
dv/tb_sha256_message_hasher.sv
